// ----- sv/u8u2_pkg.sv -----
package u8u2_pkg;

    // byte class boundaries and masks
    localparam logic [7:0]  LEAD2_BASE  = 8'hC0;
    localparam logic [7:0]  LEAD3_BASE  = 8'hE0;
    localparam logic [7:0]  LEAD4_BASE  = 8'hF0;
    localparam logic [7:0]  BAD_BASE    = 8'hF8;
    localparam logic [7:0]  ASCII_TOP   = 8'h80;
    localparam logic [5:0]  CONT_MASK   = 6'h3F;
    localparam logic [1:0]  CONT_TAG    = 2'b10;
    localparam logic [15:0] REPLACEMENT = 16'hFFFD;

    // result queue depth
    localparam int unsigned QUEUE_DEPTH = 4;

    // one decoded result as it waits in the queue
    typedef struct packed {
        logic [15:0] code;
        logic        eos;
        logic        last;
    } result_t;

    // outcome of decoding a byte with no sequence in progress
    typedef struct packed {
        logic        emit;
        logic [15:0] code;
        logic        eos;
        logic [1:0]  pend;
        logic [15:0] acc;
        logic        skip;
    } fresh_t;

    function automatic fresh_t decode_fresh(logic [7:0] b);
        fresh_t f;
        f = '0;
        priority if (b < ASCII_TOP)
        begin
            f.emit = 1'b1;
            f.code = {8'h00, b};
            f.eos  = (b == 8'h00);
        end
        else if (b < LEAD2_BASE)
        begin
            f.emit = 1'b1;
            f.code = REPLACEMENT;
        end
        else if (b < LEAD3_BASE)
        begin
            f.pend = 2'd1;
            f.acc  = {5'b0, b[4:0], 6'b0};
        end
        else if (b < LEAD4_BASE)
        begin
            f.pend = 2'd2;
            f.acc  = {b[3:0], 12'b0};
        end
        else if (b < BAD_BASE)
        begin
            f.pend = 2'd3;
            f.skip = 1'b1;
        end
        else
        begin
            f.emit = 1'b1;
            f.code = REPLACEMENT;
        end
        return f;
    endfunction

endpackage

// ----- sv/utf8_to_ucs2_stream_decoder.sv -----
// an accepted byte's results are registered into the result queue, whose head drives the outputs
// throughput: one byte per cycle while in_stall is low; a byte that yields two results adds
// one more result to the output side, and the four-entry result queue stalls input only when three
// or more results are waiting
// reset (rst_n low, asynchronous): no sequence in progress, result queue empty
module utf8_to_ucs2_stream_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] code_unit,
    output logic        end_of_string,
    output logic        last
);

    localparam int unsigned CW = $clog2(u8u2_pkg::QUEUE_DEPTH + 1);

    logic [1:0]             pend_reg, pend_next;
    logic [15:0]            acc_reg, acc_next;
    logic                   skip_reg, skip_next;
    u8u2_pkg::result_t      q_reg [u8u2_pkg::QUEUE_DEPTH];
    u8u2_pkg::result_t      q_next [u8u2_pkg::QUEUE_DEPTH];
    logic [CW-1:0]          cnt_reg, cnt_next;

    logic                   in_acc, out_acc;
    u8u2_pkg::fresh_t       fr;
    u8u2_pkg::result_t      r0, r1;
    logic [1:0]             n_res;
    logic [1:0]             np;
    logic [15:0]            cont_shift, acc_or;
    logic [CW-1:0]          base;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    // room for two results is required before taking a byte
    assign in_stall  = (cnt_reg > CW'(u8u2_pkg::QUEUE_DEPTH - 2));
    assign out_valid = (cnt_reg != '0);
    assign code_unit     = q_reg[0].code;
    assign end_of_string = q_reg[0].eos;
    assign last          = q_reg[0].last;

    // continuation bits placed by remaining count
    assign np = pend_reg - 2'd1;
    always_comb
    begin
        unique case (np)
            2'd1:    cont_shift = {4'b0, in_byte[5:0], 6'b0};
            2'd2:    cont_shift = {in_byte[3:0], 12'b0};
            default: cont_shift = {10'b0, in_byte[5:0]};
        endcase
    end
    assign acc_or = acc_reg | cont_shift;

    // byte decode and sequence state update
    always_comb
    begin
        fr        = u8u2_pkg::decode_fresh(in_byte);
        n_res     = 2'd0;
        r0        = '0;
        r1        = '0;
        pend_next = pend_reg;
        acc_next  = acc_reg;
        skip_next = skip_reg;
        if (pend_reg != 2'd0)
        begin
            if (in_byte[7:6] == u8u2_pkg::CONT_TAG)
            begin
                pend_next = np;
                if (!skip_reg)
                begin
                    acc_next = acc_or;
                end
                if (np == 2'd0)
                begin
                    r0.code   = skip_reg ? u8u2_pkg::REPLACEMENT : acc_or;
                    r0.eos    = !skip_reg && (acc_or == 16'h0000);
                    n_res     = 2'd1;
                    acc_next  = '0;
                    skip_next = 1'b0;
                end
            end
            else
            begin
                // missing continuation: replacement, then decode the byte afresh
                r0.code   = u8u2_pkg::REPLACEMENT;
                r1.code   = fr.code;
                r1.eos    = fr.eos;
                n_res     = fr.emit ? 2'd2 : 2'd1;
                pend_next = fr.pend;
                acc_next  = fr.acc;
                skip_next = fr.skip;
            end
        end
        else
        begin
            r0.code   = fr.code;
            r0.eos    = fr.eos;
            n_res     = {1'b0, fr.emit};
            pend_next = fr.pend;
            acc_next  = fr.acc;
            skip_next = fr.skip;
        end
        r0.last = (n_res == 2'd1);
        r1.last = 1'b1;
    end

    // result queue: head at entry 0, shift on pop, append at the tail
    always_comb
    begin
        base = cnt_reg - CW'(out_acc);
        for (int i = 0; i < u8u2_pkg::QUEUE_DEPTH; i++)
        begin
            if (out_acc && (i < u8u2_pkg::QUEUE_DEPTH - 1))
            begin
                q_next[i] = q_reg[i + 1];
            end
            else
            begin
                q_next[i] = q_reg[i];
            end
            if (in_acc && (n_res != 2'd0) && (base == CW'(i)))
            begin
                q_next[i] = r0;
            end
            if (in_acc && (n_res == 2'd2) && (base + CW'(1) == CW'(i)))
            begin
                q_next[i] = r1;
            end
        end
        cnt_next = base + (in_acc ? CW'(n_res) : CW'(0));
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
            acc_reg  <= '0;
            skip_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (in_acc)
            begin
                pend_reg <= pend_next;
                acc_reg  <= acc_next;
                skip_reg <= skip_next;
            end
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < u8u2_pkg::QUEUE_DEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    // queue never overfills
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(u8u2_pkg::QUEUE_DEPTH))
        else $error("result queue overfilled");

    // skipping a four-byte sequence only while continuations are pending and nothing is accumulated
    a_skip_pend: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg |-> (pend_reg != 2'd0) && (acc_reg == 16'h0000))
        else $error("skip flag without pending sequence");

    // an ascii byte outside a sequence always yields a result next cycle
    a_ascii_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (pend_reg == 2'd0) && !in_byte[7]) |=> out_valid)
        else $error("ascii byte produced no result");

endmodule

// ----- bench/utf8_to_ucs2_stream_decoder_tb.sv -----
module utf8_to_ucs2_stream_decoder_tb;

    localparam int RANDOM_BYTES  = 1000;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 20;

    // one decoded code unit as the checker expects it
    typedef struct packed {
        logic [15:0] code;
        logic        eos;
        logic        last;
    } unit_t;

    // one byte waiting to be sent; drain_first holds it until all results are in
    typedef struct packed {
        logic [7:0] value;
        logic       drain_first;
    } feed_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] code_unit;
    logic        end_of_string;
    logic        last;

    feed_item_t  byte_feed [$];
    unit_t       expected_units [$];

    // decoder state as predicted
    logic [1:0]  seq_remaining = 2'd0;
    logic [15:0] seq_bits = 16'h0000;
    logic        seq_skip4 = 1'b0;

    int          mismatches = 0;
    int          results_outstanding = 0;
    int          quiet_cycles = 0;
    logic        feeder_idle = 1'b0;
    int          gap_left = 0;
    int          burst_left = 0;
    int          stall_run = 0;

    logic [7:0]  directed_bytes [0:26] = '{
        8'h00, 8'h7F, 8'h80, 8'hBF, 8'hF8, 8'hFF,
        8'hC2, 8'hA9,
        8'hE2, 8'h82, 8'hAC,
        8'hC0, 8'h80,
        8'hF0, 8'h9F, 8'h98, 8'h80,
        8'hC3, 8'h00,
        8'hE2, 8'h41,
        8'hED, 8'hA0, 8'h80,
        8'hE2, 8'h82, 8'hF8
    };

    utf8_to_ucs2_stream_decoder i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .code_unit     (code_unit),
        .end_of_string (end_of_string),
        .last          (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // work out the code units one accepted byte gives and queue them
    task automatic decode_utf8_byte(input logic [7:0] b);
        unit_t produced [2];
        int    n;
        int    i;
        logic  fresh;
        n = 0;
        fresh = 1'b1;
        if (seq_remaining != 2'd0)
        begin
            if (b[7:6] == u8u2_pkg::CONT_TAG)
            begin
                fresh = 1'b0;
                seq_remaining = seq_remaining - 2'd1;
                if (!seq_skip4)
                    seq_bits = seq_bits |
                               ({10'b0, b[5:0] & u8u2_pkg::CONT_MASK} << (6 * seq_remaining));
                if (seq_remaining == 2'd0)
                begin
                    produced[n].code = seq_skip4 ? u8u2_pkg::REPLACEMENT : seq_bits;
                    produced[n].eos  = !seq_skip4 && (seq_bits == 16'h0000);
                    n++;
                    seq_bits = 16'h0000;
                    seq_skip4 = 1'b0;
                end
            end
            else
            begin
                // missing continuation: drop the sequence, then decode the byte anew
                produced[n] = '{u8u2_pkg::REPLACEMENT, 1'b0, 1'b0};
                n++;
                seq_remaining = 2'd0;
                seq_bits = 16'h0000;
                seq_skip4 = 1'b0;
            end
        end
        if (fresh)
        begin
            if (b < u8u2_pkg::ASCII_TOP)
            begin
                produced[n].code = {8'h00, b};
                produced[n].eos  = (b == 8'h00);
                n++;
            end
            else if (b < u8u2_pkg::LEAD2_BASE)
            begin
                produced[n] = '{u8u2_pkg::REPLACEMENT, 1'b0, 1'b0};
                n++;
            end
            else if (b < u8u2_pkg::LEAD3_BASE)
            begin
                seq_bits = {5'b0, b[4:0], 6'b0};
                seq_remaining = 2'd1;
                seq_skip4 = 1'b0;
            end
            else if (b < u8u2_pkg::LEAD4_BASE)
            begin
                seq_bits = {b[3:0], 12'b0};
                seq_remaining = 2'd2;
                seq_skip4 = 1'b0;
            end
            else if (b < u8u2_pkg::BAD_BASE)
            begin
                seq_bits = 16'h0000;
                seq_remaining = 2'd3;
                seq_skip4 = 1'b1;
            end
            else
            begin
                produced[n] = '{u8u2_pkg::REPLACEMENT, 1'b0, 1'b0};
                n++;
            end
        end
        for (i = 0; i < n; i++)
        begin
            produced[i].last = (i == n - 1);
            expected_units.push_back(produced[i]);
        end
    endtask

    // mostly well-formed sequences with random content, some truncated, some noise
    task automatic add_random_sequence(input logic drain_first);
        int         kind;
        int         conts;
        int         i;
        logic [7:0] lead;
        kind = $urandom_range(0, 99);
        conts = 0;
        if (kind < 30)
            lead = ($urandom_range(0, 19) == 0) ? 8'h00 : 8'($urandom_range(1, 127));
        else if (kind < 52)
        begin
            lead = 8'($urandom_range(8'hC0, 8'hDF));
            conts = 1;
        end
        else if (kind < 74)
        begin
            lead = 8'($urandom_range(8'hE0, 8'hEF));
            conts = 2;
        end
        else if (kind < 84)
        begin
            lead = 8'($urandom_range(8'hF0, 8'hF7));
            conts = 3;
        end
        else
            lead = 8'($urandom_range(0, 255));
        // cut some sequences short so the next lead interrupts them
        if (conts > 0 && $urandom_range(0, 9) == 0)
            conts = $urandom_range(0, conts - 1);
        byte_feed.push_back('{lead, drain_first});
        for (i = 0; i < conts; i++)
            byte_feed.push_back('{8'($urandom_range(8'h80, 8'hBF)), 1'b0});
    endtask

    // stimulus and end of run
    initial
    begin
        int   directed_count;
        logic timed_out;
        foreach (directed_bytes[k])
            byte_feed.push_back('{directed_bytes[k], 1'b0});
        directed_count = byte_feed.size();
        add_random_sequence(1'b1);
        while (byte_feed.size() < directed_count + RANDOM_BYTES)
            add_random_sequence($urandom_range(0, 149) == 0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        timed_out = 1'b0;
        while (!timed_out && !(feeder_idle && results_outstanding == 0))
        begin
            @(posedge clk);
            if (quiet_cycles >= QUIET_LIMIT)
                timed_out = 1'b1;
        end
        if (timed_out)
            $display("Mismatches found");
        else
        begin
            repeat (SETTLE_CYCLES) @(posedge clk);
            if (expected_units.size() != 0)
            begin
                $error("%0d expected code units never arrived", expected_units.size());
                mismatches++;
            end
            if (mismatches == 0)
                $display("No mismatches found");
            else
                $display("Mismatches found");
        end
        $finish;
    end

    // byte driver: bursts and gaps, holds a stalled request
    always @(posedge clk)
    begin
        logic next_valid;
        next_valid = in_valid;
        if (rst_n && (!in_valid || !in_stall))
        begin
            next_valid = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (byte_feed.size() > 0 &&
                     !(byte_feed[0].drain_first && (in_valid || results_outstanding != 0)))
            begin
                next_valid = 1'b1;
                in_byte <= byte_feed[0].value;
                void'(byte_feed.pop_front());
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
                end
            end
            in_valid <= next_valid;
        end
        feeder_idle <= (byte_feed.size() == 0) && !next_valid;
    end

    // monitor: predict accepted bytes, check accepted code units, drive out_stall
    always @(posedge clk)
    begin
        unit_t want;
        logic  took_byte;
        logic  took_unit;
        if (rst_n)
        begin
            took_byte = in_valid && !in_stall;
            took_unit = out_valid && !out_stall;
            if (took_byte)
                decode_utf8_byte(in_byte);
            if (took_unit)
            begin
                if (expected_units.size() == 0)
                begin
                    $error("unexpected result: code_unit %h end_of_string %b last %b",
                           code_unit, end_of_string, last);
                    mismatches++;
                end
                else
                begin
                    want = expected_units.pop_front();
                    if (code_unit !== want.code)
                    begin
                        $error("code_unit: expected %h, got %h", want.code, code_unit);
                        mismatches++;
                    end
                    if (end_of_string !== want.eos)
                    begin
                        $error("end_of_string: expected %b, got %b", want.eos, end_of_string);
                        mismatches++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %b, got %b", want.last, last);
                        mismatches++;
                    end
                end
            end
            results_outstanding <= expected_units.size();
            quiet_cycles <= (took_byte || took_unit) ? 0 : quiet_cycles + 1;

            // receiver stall pattern: long open runs, short and long stalls
            if (stall_run > 0)
                stall_run--;
            else
            begin
                out_stall <= !out_stall;
                if (out_stall)
                    stall_run = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
                                                            : $urandom_range(0, 8);
                else
                    stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                            : $urandom_range(0, 3);
            end
        end
    end

endmodule
